// ===== sv/i16dec_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i16dec_pkg: shared types and constants for the decimal text formatter
// Character codes, stage counts and the item passed from front to back.
// ---------------------------------------------------------------------------
package i16dec_pkg;

  localparam int MAX_FIELD_WIDTH = 8;
  localparam int QUEUE_DEPTH     = 2;
  // Four divide-by-ten stages; the final quotient is the fifth digit.
  localparam int DIV_STAGES      = 4;
  localparam int NUM_DIGITS      = DIV_STAGES + 1;
  localparam int BCD_W           = 4 * NUM_DIGITS;

  // Reciprocal of ten: (x * 52429) >> 19 equals x / 10 for all 16-bit x.
  localparam logic [31:0] RECIP_TEN = 32'd52429;
  localparam int          RECIP_SH  = 19;

  localparam logic [6:0] CH_STAR  = 7'd42;
  localparam logic [6:0] CH_SPACE = 7'd32;
  localparam logic [6:0] CH_MINUS = 7'd45;
  localparam logic [6:0] CH_ZERO  = 7'd48;

  typedef struct packed {
    logic       neg;
    logic [3:0] width;
    logic       star;
    logic [3:0] blank;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic [BCD_W-1:0] bcd;
  } item_t;

endpackage

// ===== sv/i16dec_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i16dec_front: accepts items, classifies them and extracts decimal digits
// A stage of sign and fit classification, then one divide-by-ten per stage.
// ---------------------------------------------------------------------------
module i16dec_front #(
  parameter int MAX_FIELD_WIDTH = i16dec_pkg::MAX_FIELD_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  value,
  input  logic [3:0]          field_width,
  output logic                q_valid,
  input  logic                q_ready,
  output i16dec_pkg::item_t   q_item
);

  localparam int NSTG = i16dec_pkg::DIV_STAGES;
  localparam logic [3:0] WMAX = (MAX_FIELD_WIDTH > 15) ? 4'd15 : 4'(MAX_FIELD_WIDTH);

  logic                  stg_valid [0:NSTG];
  logic [15:0]           quo       [0:NSTG];
  logic [4*NSTG-1:0]     digs      [0:NSTG];
  i16dec_pkg::meta_t     meta      [0:NSTG];

  logic [31:0]           prod      [1:NSTG];
  logic [15:0]           qt        [1:NSTG];
  logic [15:0]           rm        [1:NSTG];
  logic [4*NSTG-1:0]     digs_next [1:NSTG];

  logic                  advance;
  logic                  neg;
  logic [3:0]            width_sat;
  logic [15:0]           mag;
  logic [3:0]            ndig;
  logic [3:0]            avail;
  i16dec_pkg::meta_t     meta_in;

  always_comb begin
    neg       = value[15];
    width_sat = (field_width > WMAX) ? WMAX : field_width;
    mag       = neg ? (~$unsigned(value) + 16'd1) : $unsigned(value);
    ndig      = 4'd1 + 4'(mag >= 16'd10) + 4'(mag >= 16'd100) + 4'(mag >= 16'd1000)
              + 4'(mag >= 16'd10000);
    avail     = width_sat - {3'b000, neg};
    meta_in.neg   = neg;
    meta_in.width = width_sat;
    meta_in.star  = (ndig > avail);
    meta_in.blank = width_sat - ndig;
  end

  always_comb begin
    for (int k = 1; k <= NSTG; k++) begin
      prod[k] = {16'd0, quo[k-1]} * i16dec_pkg::RECIP_TEN;
      qt[k]   = {3'b000, prod[k][31:i16dec_pkg::RECIP_SH]};
      rm[k]   = quo[k-1] - ((qt[k] << 3) + (qt[k] << 1));
      digs_next[k] = digs[k-1];
      digs_next[k][(k-1)*4 +: 4] = rm[k][3:0];
    end
  end

  assign advance  = !stg_valid[NSTG] || q_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NSTG; k++) begin
        stg_valid[k] <= 1'b0;
      end
    end else if (advance) begin
      // A zero-width item produces no characters and is dropped here.
      stg_valid[0] <= in_valid && (width_sat != 4'd0);
      for (int k = 1; k <= NSTG; k++) begin
        stg_valid[k] <= stg_valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      quo[0]  <= mag;
      digs[0] <= '0;
      meta[0] <= meta_in;
      for (int k = 1; k <= NSTG; k++) begin
        quo[k]  <= qt[k];
        digs[k] <= digs_next[k];
        meta[k] <= meta[k-1];
      end
    end
  end

  assign q_valid     = stg_valid[NSTG];
  assign q_item.meta = meta[NSTG];
  assign q_item.bcd  = {quo[NSTG][3:0], digs[NSTG]};

endmodule

// ===== sv/i16dec_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i16dec_queue: small first-in first-out queue between front and back
// Register-based entries with read and write pointers and an occupancy count.
// ---------------------------------------------------------------------------
module i16dec_queue #(
  parameter int DEPTH = i16dec_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  i16dec_pkg::item_t push_item,
  output logic              pop_valid,
  input  logic              pop_ready,
  output i16dec_pkg::item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  i16dec_pkg::item_t entry [0:DEPTH-1];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              push;
  logic              pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_ready && pop_valid;
  assign pop_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== sv/i16dec_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i16dec_back: emits one field's characters, one per cycle unless stalled
// Walks the positions left to right into a registered output stage.
// ---------------------------------------------------------------------------
module i16dec_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  i16dec_pkg::item_t q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [6:0]        char_code,
  output logic [2:0]        position,
  output logic              last
);

  logic              busy;
  i16dec_pkg::item_t cur;
  logic [3:0]        pos;
  logic              emit;
  logic              at_end;
  logic              finishing;
  logic              pop;

  function automatic logic [6:0] char_of(input i16dec_pkg::item_t it, input logic [3:0] p);
    logic [3:0] idx;
    logic [3:0] dig;
    logic [6:0] ch;
    idx = it.meta.width - 4'd1 - p;
    case (idx)
      4'd0:    dig = it.bcd[3:0];
      4'd1:    dig = it.bcd[7:4];
      4'd2:    dig = it.bcd[11:8];
      4'd3:    dig = it.bcd[15:12];
      4'd4:    dig = it.bcd[19:16];
      default: dig = 4'd0;
    endcase
    if (it.meta.neg && (p == 4'd0) && (it.meta.width != 4'd1)) begin
      ch = i16dec_pkg::CH_MINUS;
    end else if (it.meta.star) begin
      ch = i16dec_pkg::CH_STAR;
    end else if (p < it.meta.blank) begin
      ch = i16dec_pkg::CH_SPACE;
    end else begin
      ch = i16dec_pkg::CH_ZERO + {3'b000, dig};
    end
    return ch;
  endfunction

  assign emit      = busy && (!out_valid || out_ready);
  assign at_end    = (pos == cur.meta.width - 4'd1);
  assign finishing = emit && at_end;
  assign pop       = q_valid && (!busy || finishing);
  assign q_ready   = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      pos       <= 4'd0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (finishing) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        pos <= 4'd0;
      end else if (emit) begin
        pos <= pos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_item;
    end
    if (emit) begin
      char_code <= char_of(cur, pos);
      position  <= pos[2:0];
      last      <= at_end;
    end
  end

endmodule

// ===== sv/int16_to_fixed_width_decimal_text.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// int16_to_fixed_width_decimal_text: signed 16-bit value to decimal text
// Formats a value into a right-justified ASCII field, one character per item.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_ready  | value, field_width
//   out     | output    | out_valid / out_ready| char_code, position, last
//
// An input item becomes field_width output items (saturated to
// MAX_FIELD_WIDTH); a zero width gives none. The back end emits one character
// per cycle while the output is not stalled. The front end is a five-stage
// pipeline (classification, then four divide-by-ten stages) that takes an
// item every cycle while the queue has room. Synchronous reset clears all
// valid bits, queue pointers and counters. A stall on the output holds the
// back end only; the front end keeps accepting items until its pipeline
// and the queue between them are full.
//
// Negative values put a minus sign in the leftmost position and format the
// magnitude behind it; -32768 prints as its true magnitude. When the digits
// do not fit, every position after the sign is filled with asterisks, and a
// negative value in a one-character field prints a single asterisk.
//
module int16_to_fixed_width_decimal_text #(
  parameter int MAX_FIELD_WIDTH = i16dec_pkg::MAX_FIELD_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] value,
  input  logic [3:0]         field_width,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         char_code,
  output logic [2:0]         position,
  output logic               last
);

  // Front end to queue.
  logic              fr_valid;
  logic              fr_ready;
  i16dec_pkg::item_t fr_item;

  // Queue to back end.
  logic              bk_valid;
  logic              bk_ready;
  i16dec_pkg::item_t bk_item;

  i16dec_front #(
    .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .field_width(field_width),
    .q_valid    (fr_valid),
    .q_ready    (fr_ready),
    .q_item     (fr_item)
  );

  i16dec_queue #(
    .DEPTH(i16dec_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fr_valid),
    .push_ready(fr_ready),
    .push_item (fr_item),
    .pop_valid (bk_valid),
    .pop_ready (bk_ready),
    .pop_item  (bk_item)
  );

  i16dec_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (bk_valid),
    .q_ready  (bk_ready),
    .q_item   (bk_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .char_code(char_code),
    .position (position),
    .last     (last)
  );

endmodule
